// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Combinational invariant checked every clock outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ----- hdl/ffia_pkg.sv -----
// ---------------------------------------------------------------------------
// ffia_pkg: shared types and constants
// Item formats and default sizes of the first-fit interval assigner.
// ---------------------------------------------------------------------------
package ffia_pkg;

    localparam int ID_W          = 16;
    localparam int FIELD_TIME_W  = 16;
    localparam int WORKER_W      = 3;
    localparam int NUM_WORKERS_DEF = 8;
    localparam int TIME_BITS_DEF   = 16;

    // One task entering the block
    typedef struct packed {
        logic [ID_W-1:0]         task_id;
        logic [FIELD_TIME_W-1:0] start_time;
        logic [FIELD_TIME_W-1:0] finish_time;
        logic                    last_of_set;
    } task_item_t;

    // One assignment result
    typedef struct packed {
        logic [ID_W-1:0]     task_out;
        logic [WORKER_W-1:0] worker;
        logic                unassigned;
    } result_item_t;

endpackage

// ----- hdl/first_fit_interval_assigner_top.sv -----
// ---------------------------------------------------------------------------
// first_fit_interval_assigner_top: first-fit task to worker assignment
// Gives each task to the lowest worker that is free at the task's start.
// ---------------------------------------------------------------------------
//  channel   signals                                 direction
//  task      task_valid, task_stall, task_data       in  (task_stall driven here)
//  result    result_valid, result_stall, result_data out (result_stall driven outside)
//
//  One item per cycle sustained while results are not stalled; each item
//  waits in the input register, is assigned there by a parallel compare
//  over all workers with a priority pick, and moves to the result register.
//  Reset clears the valid flags and the worker busy flags; no clearing pass.
//  A stalled result holds the input register, which then stalls the task side.
//  Worker state clears in the same cycle the item marked last is assigned.
`include "assert_macros.svh"

module first_fit_interval_assigner_top #(
    parameter int NUM_WORKERS = ffia_pkg::NUM_WORKERS_DEF,
    parameter int TIME_BITS   = ffia_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  task_valid,
    output logic                  task_stall,
    input  ffia_pkg::task_item_t  task_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output ffia_pkg::result_item_t result_data
);

    // time bits actually compared: the input fields cap the width
    localparam int UB = (TIME_BITS < ffia_pkg::FIELD_TIME_W) ? TIME_BITS
                                                             : ffia_pkg::FIELD_TIME_W;

    // input register
    logic                 task_valid_reg;
    ffia_pkg::task_item_t task_reg;

    // result register
    logic                   result_valid_reg;
    ffia_pkg::result_item_t result_reg;
    ffia_pkg::result_item_t result_next;

    // worker state
    logic [NUM_WORKERS-1:0] in_use_reg;
    logic [NUM_WORKERS-1:0] in_use_next;
    logic [UB-1:0]          last_finish_reg  [NUM_WORKERS];
    logic [UB-1:0]          last_finish_next [NUM_WORKERS];

    logic                   advance;
    logic [NUM_WORKERS-1:0] fit;
    logic [NUM_WORKERS-1:0] first;
    logic                   any_fit;
    logic [UB-1:0]          start_u;
    logic [UB-1:0]          finish_u;

    // handshake
    assign advance      = task_valid_reg && (!result_valid_reg || !result_stall);
    assign task_stall   = task_valid_reg && !advance;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign start_u  = task_reg.start_time[UB-1:0];
    assign finish_u = task_reg.finish_time[UB-1:0];

    // parallel fit test and priority pick
    always_comb
    begin
        logic lower;
        lower = 1'b0;
        for (int w = 0; w < NUM_WORKERS; w++)
        begin
            fit[w]   = !in_use_reg[w] || (last_finish_reg[w] <= start_u);
            first[w] = fit[w] && !lower;
            lower    = lower || fit[w];
        end
        any_fit = lower;
    end

    // result and state update
    always_comb
    begin
        result_next.task_out   = task_reg.task_id;
        result_next.worker     = '0;
        result_next.unassigned = !any_fit;
        in_use_next            = in_use_reg;
        for (int w = 0; w < NUM_WORKERS; w++)
        begin
            last_finish_next[w] = last_finish_reg[w];
            if (first[w])
            begin
                result_next.worker  = ffia_pkg::WORKER_W'(w);
                in_use_next[w]      = 1'b1;
                last_finish_next[w] = finish_u;
            end
        end
        if (task_reg.last_of_set)
        begin
            in_use_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            in_use_reg       <= '0;
        end
        else
        begin
            if (!task_stall)
            begin
                task_valid_reg <= task_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                in_use_reg       <= in_use_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!task_stall && task_valid)
        begin
            task_reg <= task_data;
        end
        if (advance)
        begin
            result_reg <= result_next;
            for (int w = 0; w < NUM_WORKERS; w++)
            begin
                last_finish_reg[w] <= last_finish_next[w];
            end
        end
    end

    // checks
    `ASSERT_IMPL(a_adv_result, clk, rst_n, advance, result_valid_reg,
                 "assigned item did not reach result register")
    `ASSERT_IMPL(a_last_clears, clk, rst_n, advance && task_reg.last_of_set,
                 in_use_reg == '0, "worker state not cleared after last item")
    `ASSERT_IMPL(a_nofit_flag, clk, rst_n, advance && !any_fit,
                 result_reg.unassigned && (result_reg.worker == '0),
                 "unfitted task not flagged unassigned")
    `ASSERT_ALWAYS(a_pick_onehot, clk, rst_n, $onehot0(first) && (any_fit == (first != '0)),
                   "priority pick not one-hot")

endmodule

// ----- verif/tb_first_fit_interval_assigner_top.sv -----
// ---------------------------------------------------------------------------
// tb_first_fit_interval_assigner_top: self-checking bench for the assigner
// Feeds task items over the valid/stall channel, predicts the first-fit
// worker for each accepted task and compares every result item in order.
// ---------------------------------------------------------------------------
module tb_first_fit_interval_assigner_top;

    localparam int N_WORKERS = ffia_pkg::NUM_WORKERS_DEF;
    localparam int TIME_W    = ffia_pkg::TIME_BITS_DEF;
    localparam int LONG_HOLD = 80;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   task_valid = 1'b0;
    logic                   task_stall;
    ffia_pkg::task_item_t   task_data = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    ffia_pkg::result_item_t result_data;

    // Predicted worker state
    logic [TIME_W-1:0] busy_until [N_WORKERS];
    logic              has_task   [N_WORKERS];

    ffia_pkg::result_item_t pending_assignments[$];
    int                     mismatch_count = 0;

    // Idling controls, written only by the test sequence
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;
    int hold_requests  = 0;

    // Receiver side bookkeeping
    int holds_served = 0;
    int hold_left    = 0;

    first_fit_interval_assigner_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_stall   (task_stall),
        .task_data    (task_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Clear all predicted worker state
    function automatic void clear_workers();
        for (int w = 0; w < N_WORKERS; w++)
        begin
            busy_until[w] = '0;
            has_task[w]   = 1'b0;
        end
    endfunction

    // First-fit pick: lowest worker that is unused or free by the start time
    function automatic ffia_pkg::result_item_t assign_task(input ffia_pkg::task_item_t t);
        ffia_pkg::result_item_t r;
        logic [TIME_W-1:0]      st;
        logic [TIME_W-1:0]      fin;
        int                     pick;
        st   = t.start_time[TIME_W-1:0];
        fin  = t.finish_time[TIME_W-1:0];
        pick = -1;
        for (int w = 0; w < N_WORKERS; w++)
        begin
            if (pick < 0 && (!has_task[w] || busy_until[w] <= st))
                pick = w;
        end
        r.task_out = t.task_id;
        if (pick >= 0)
        begin
            has_task[pick]   = 1'b1;
            busy_until[pick] = fin;
            r.worker         = ffia_pkg::WORKER_W'(pick);
            r.unassigned     = 1'b0;
        end
        else
        begin
            r.worker     = '0;
            r.unassigned = 1'b1;
        end
        if (t.last_of_set)
            clear_workers();
        return r;
    endfunction

    // Compare one result item against the oldest prediction
    task automatic check_result(input ffia_pkg::result_item_t got);
        ffia_pkg::result_item_t want;
        if (pending_assignments.size() == 0)
        begin
            $error("unexpected result item: task_out %0d worker %0d unassigned %0b",
                   got.task_out, got.worker, got.unassigned);
            mismatch_count++;
        end
        else
        begin
            want = pending_assignments.pop_front();
            if (got.task_out !== want.task_out)
            begin
                $error("task_out mismatch: expected %0d, actual %0d",
                       want.task_out, got.task_out);
                mismatch_count++;
            end
            if (got.worker !== want.worker)
            begin
                $error("worker mismatch: expected %0d, actual %0d (task %0d)",
                       want.worker, got.worker, want.task_out);
                mismatch_count++;
            end
            if (got.unassigned !== want.unassigned)
            begin
                $error("unassigned mismatch: expected %0b, actual %0b (task %0d)",
                       want.unassigned, got.unassigned, want.task_out);
                mismatch_count++;
            end
        end
    endtask

    // Monitor: predict on task acceptance, then check result acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (task_valid && !task_stall)
                pending_assignments.push_back(assign_task(task_data));
            if (result_valid && !result_stall)
                check_result(result_data);
        end
    end

    // Receiver: random stalls, or a long hold when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            result_stall <= 1'b1;
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD;
        end
        else
            result_stall <= receiver_idles && ($urandom_range(99) < 32);
    end

    // Offer one item and wait until it is taken
    task automatic send_task(input ffia_pkg::task_item_t t);
        while (sender_idles && $urandom_range(99) < 32)
        begin
            task_valid <= 1'b0;
            @(posedge clk);
        end
        task_valid <= 1'b1;
        task_data  <= t;
        @(posedge clk);
        while (task_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [15:0] id, input logic [15:0] st,
                               input logic [15:0] fin, input logic last);
        ffia_pkg::task_item_t t;
        t.task_id     = id;
        t.start_time  = st;
        t.finish_time = fin;
        t.last_of_set = last;
        send_task(t);
    endtask

    // Sender goes quiet until every predicted result has come back
    task automatic wait_all_assigned();
        task_valid <= 1'b0;
        @(posedge clk);
        while (pending_assignments.size() != 0)
            @(posedge clk);
    endtask

    // Sorted task sets with random content, plus some unsorted noise
    task automatic run_task_sets(input int n_items);
        int                   sent;
        int                   set_len;
        int                   fin;
        int                   dur;
        int                   max_dur;
        ffia_pkg::task_item_t t;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                set_len = $urandom_range(1, 24);
                max_dur = $urandom_range(10, 400);
                fin     = ($urandom_range(1) == 1) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 300);
                for (int i = 0; i < set_len; i++)
                begin
                    fin = fin + $urandom_range(0, 40);
                    if (fin > 65535)
                        fin = 65535;
                    dur = $urandom_range(0, max_dur);
                    t.task_id     = 16'($urandom);
                    t.finish_time = 16'(fin);
                    t.start_time  = (dur > fin) ? 16'd0 : 16'(fin - dur);
                    t.last_of_set = (i == set_len - 1);
                    send_task(t);
                    sent++;
                end
            end
            else
            begin
                t.task_id     = 16'($urandom);
                t.start_time  = 16'($urandom);
                t.finish_time = 16'($urandom);
                t.last_of_set = ($urandom_range(99) < 25);
                send_task(t);
                sent++;
            end
        end
    endtask

    // Field extremes, full occupancy, no fit, boundary and unsorted cases
    task automatic test_directed();
        // eight overlapping tasks take every worker, the ninth finds none
        for (int i = 0; i < N_WORKERS + 1; i++)
            send_fields(16'(i), 16'd10, 16'd100, 1'b0);
        // start equal to a last finish still fits
        send_fields(16'h8000, 16'd100, 16'd200, 1'b0);
        // no fit on the last item of a set; state still clears
        send_fields(16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        // start after finish on a fresh worker
        send_fields(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_fields(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_fields(16'h5555, 16'hFFFF, 16'hFFFF, 1'b0);
        // finish earlier than the one before
        send_fields(16'hAAAA, 16'd3, 16'd5, 1'b0);
        send_fields(16'h1234, 16'd4, 16'd4, 1'b1);
        // fresh set after a clear reuses worker zero
        send_fields(16'h00FF, 16'd0, 16'd0, 1'b1);
        send_fields(16'hFF00, 16'hFFFF, 16'hFFFF, 1'b1);
        wait_all_assigned();
    endtask

    task automatic test_random_traffic(input int n_items);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        run_task_sets(n_items);
    endtask

    // Back to back items, no idling on either side
    task automatic test_steady_stream(input int n_items);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        run_task_sets(n_items);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_result_backpressure(input int n_items);
        sender_idles  = 1'b0;
        hold_requests = hold_requests + 1;
        run_task_sets(n_items);
        sender_idles  = 1'b1;
        wait_all_assigned();
    endtask

    // Sender stops until all results are in, then resumes
    task automatic test_sender_pause(input int n_items);
        run_task_sets(n_items);
        wait_all_assigned();
        run_task_sets(n_items);
    endtask

    initial
    begin
        clear_workers();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_traffic(200);
        test_steady_stream(120);
        test_result_backpressure(40);
        test_sender_pause(25);
        test_random_traffic(220);

        wait_all_assigned();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_assignments.size() == 0)
            $display("tb_first_fit_interval_assigner_top passed");
        else
            $display("tb_first_fit_interval_assigner_top failed");
        $finish;
    end

    // Run time limit
    initial
    begin
        #(12 * 300000);
        $display("tb_first_fit_interval_assigner_top failed");
        $finish;
    end

endmodule
